/* src/picm_pkg.sv */
// ----------------------------------------------------------------------------
// picm_pkg: shared types and constants for the PI current controller
// Mode codes, sequencer states, register indexes, fixed field widths and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package picm_pkg;

  // fixed field widths
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int PCT_W      = 8;
  localparam int PERIOD_W   = 12;
  localparam int AMP_W      = 12;
  localparam int REF_W      = AMP_W + 1;
  localparam int HP_W       = 8;
  localparam int PTS_W      = 8;
  localparam int IDX_W      = 8;
  localparam int DUTY_W     = 12;
  localparam int MODE_W     = 3;

  // serial datapath widths
  localparam int MAG_W      = 19;   // holds 100 * 2^12
  localparam int DIV_W      = 19;   // dividend / quotient bits
  localparam int DVS_W      = 8;    // divisor bits

  localparam int PCT_SCALE  = 100;
  localparam int FULL_SCALE = PCT_SCALE * (1 << GAIN_FRAC);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LOOP_PCT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_AMPLITUDE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_HALF_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_POINTS     = 3'd6;

  localparam logic [GAIN_W-1:0]   RST_PROP_GAIN       = 16'd410;
  localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN      = 16'd2048;
  localparam logic [PCT_W-1:0]    RST_OPEN_LOOP_PCT   = 8'd0;
  localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD      = 12'd3999;
  localparam logic [AMP_W-1:0]    RST_REF_AMPLITUDE   = 12'd200;
  localparam logic [HP_W-1:0]     RST_REF_HALF_PERIOD = 8'd25;
  localparam logic [PTS_W-1:0]    RST_TEST_POINTS     = 8'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_TEST  = 3'd2,
    MODE_HOLD  = 3'd3,
    MODE_TRACK = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_TDIV,
    ST_TDIV_WAIT,
    ST_ERR,
    ST_INTEG,
    ST_MULP,
    ST_MULP_WAIT,
    ST_MULI,
    ST_MULI_WAIT,
    ST_CLAMP,
    ST_MULD,
    ST_MULD_WAIT,
    ST_DDIV,
    ST_DDIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic accum;   // add onto the previous product instead of clearing
  } mul_cmd_t;

endpackage

/* src/picm_mul.sv */
// ----------------------------------------------------------------------------
// picm_mul: bit-serial multiply-accumulate
// Signed multiplicand times unsigned gain, one multiplier bit per cycle,
// optionally added onto the running product.
// ----------------------------------------------------------------------------
module picm_mul #(
  parameter int AW = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  picm_pkg::mul_cmd_t                cmd,
  input  logic signed [AW-1:0]              a,
  input  logic [picm_pkg::GAIN_W-1:0]       b,
  output logic                              done,
  output logic signed [AW+picm_pkg::GAIN_W:0] acc
);
  import picm_pkg::*;

  localparam int PW    = AW + GAIN_W + 1;
  localparam int CNT_W = $clog2(GAIN_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [PW-1:0] a_sh_r, a_sh_nxt;
  logic [GAIN_W-1:0]    b_sh_r, b_sh_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_sh_nxt = a_sh_r;
    b_sh_nxt = b_sh_r;
    acc_nxt  = acc_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_sh_nxt = PW'(a);
      b_sh_nxt = b;
      acc_nxt  = cmd.accum ? acc_r : '0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + (b_sh_r[0] ? a_sh_r : '0);
      a_sh_nxt = a_sh_r <<< 1;
      b_sh_nxt = b_sh_r >> 1;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_sh_r <= a_sh_nxt;
    b_sh_r <= b_sh_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

/* src/picm_div.sv */
// ----------------------------------------------------------------------------
// picm_div: bit-serial restoring divider
// Unsigned dividend over a narrow divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module picm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [picm_pkg::DIV_W-1:0] dividend,
  input  logic [picm_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [picm_pkg::DIV_W-1:0] quotient
);
  import picm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    trial;
  logic              qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits DVS_W bits
      rem_nxt = qbit ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      quo_nxt = {quo_r[DIV_W-2:0], qbit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/pi_current_controller_modes_unit.sv */
// ----------------------------------------------------------------------------
// pi_current_controller_modes_unit: PI current loop with PWM duty output
// Five modes (idle, open loop, square-wave test, hold, track); PI terms run
// through a shared bit-serial multiplier, duty scaling through a serial divider.
// ----------------------------------------------------------------------------
// Per word in test, hold and track modes, the serial multiplier forms the
// two PI products and the period scaling, and the serial divider the duty
// /100 (plus the phase in test mode); open loop uses only the scaling and
// the /100, idle neither. One word in flight; the next is taken the cycle
// after the result reaches the output register.
// Synchronous active-low reset: mode idle, integrator and test tick cleared,
// registers at their defaults, no result pending.
module pi_current_controller_modes_unit #(
  parameter int CURRENT_WIDTH  = 13,
  parameter int INTEGRAL_WIDTH = 24,
  parameter int COUNT_WIDTH    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [CURRENT_WIDTH-1:0]       in_measured_current,
  input  logic signed [CURRENT_WIDTH-1:0]       in_target_current,
  input  logic                                  in_mode_write,
  input  logic [picm_pkg::MODE_W-1:0]           in_new_mode,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [picm_pkg::DUTY_W-1:0]           out_duty_count,
  output logic                                  out_reverse_dir,
  output logic                                  out_sample_valid,
  output logic [picm_pkg::IDX_W-1:0]            out_sample_index,
  output logic signed [CURRENT_WIDTH-1:0]       out_sample_current,
  output logic                                  out_test_done,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [picm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [picm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import picm_pkg::*;

  localparam int IW      = INTEGRAL_WIDTH;
  localparam int EW      = ((CURRENT_WIDTH > REF_W) ? CURRENT_WIDTH : REF_W) + 1;
  localparam int SUMW    = ((IW > EW) ? IW : EW) + 1;
  localparam int AW      = (IW > MAG_W + 1) ? IW : MAG_W + 1;
  localparam int PW      = AW + GAIN_W + 1;
  localparam int CNT_EXT = (COUNT_WIDTH > PTS_W) ? COUNT_WIDTH : PTS_W;
  localparam logic signed [PW-1:0] FS_P = PW'(FULL_SCALE);

  // configuration registers
  logic [GAIN_W-1:0]       prop_gain_r, prop_gain_nxt;
  logic [GAIN_W-1:0]       integ_gain_r, integ_gain_nxt;
  logic signed [PCT_W-1:0] open_loop_percent_r, open_loop_percent_nxt;
  logic [PERIOD_W-1:0]     pwm_period_r, pwm_period_nxt;
  logic [AMP_W-1:0]        ref_amplitude_r, ref_amplitude_nxt;
  logic [HP_W-1:0]         ref_half_period_r, ref_half_period_nxt;
  logic [PTS_W-1:0]        test_points_r, test_points_nxt;

  // control state
  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic signed [IW-1:0]    integ_r, integ_nxt;
  logic [COUNT_WIDTH-1:0]  tick_r, tick_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // word payload
  logic signed [CURRENT_WIDTH-1:0] meas_r, meas_nxt;
  logic signed [CURRENT_WIDTH-1:0] tgt_r, tgt_nxt;
  logic signed [EW-1:0]    err_r, err_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [DUTY_W-1:0]       res_duty_r, res_duty_nxt;
  logic                    res_rev_r, res_rev_nxt;

  // output register
  logic [DUTY_W-1:0]               o_duty_r, o_duty_nxt;
  logic                            o_rev_r, o_rev_nxt;
  logic                            o_sval_r, o_sval_nxt;
  logic [IDX_W-1:0]                o_sidx_r, o_sidx_nxt;
  logic signed [CURRENT_WIDTH-1:0] o_scur_r, o_scur_nxt;
  logic                            o_done_r, o_done_nxt;

  // serial units
  mul_cmd_t                mul_cmd;
  logic signed [AW-1:0]    mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic                    mul_done;
  logic signed [PW-1:0]    mul_acc;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic                    div_done;
  logic [DIV_W-1:0]        div_q;

  // misc combinational
  logic                    accept;
  logic                    ld_out;
  mode_t                   mode_upd;
  logic signed [PCT_W:0]   pct_ext;
  logic [PCT_W:0]          pct_abs;
  logic [MAG_W-1:0]        open_mag;
  logic [HP_W-1:0]         hp_eff;
  logic signed [REF_W-1:0] amp_s;
  logic signed [REF_W-1:0] test_ref;
  logic signed [EW-1:0]    ref_sel;
  logic signed [SUMW-1:0]  isum;
  logic [SUMW-IW:0]        isum_hi;
  logic signed [IW-1:0]    isat;
  logic signed [PW-1:0]    s_abs;
  logic                    smp_ok;
  logic                    test_end;

  picm_mul #(.AW(AW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mul_cmd),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .acc   (mul_acc)
  );

  picm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared helper terms
  always_comb begin
    accept   = in_valid && in_ready;
    mode_upd = (in_mode_write && (in_new_mode <= MODE_TRACK)) ?
               mode_t'(in_new_mode) : mode_r;

    pct_ext  = {open_loop_percent_r[PCT_W-1], open_loop_percent_r};
    pct_abs  = pct_ext[PCT_W] ? (PCT_W+1)'(-pct_ext) : (PCT_W+1)'(pct_ext);
    open_mag = (pct_abs > (PCT_W+1)'(PCT_SCALE)) ? MAG_W'(PCT_SCALE) : MAG_W'(pct_abs);

    hp_eff   = (ref_half_period_r == '0) ? HP_W'(1) : ref_half_period_r;
    amp_s    = $signed({1'b0, ref_amplitude_r});
    test_ref = div_q[0] ? -amp_s : amp_s;
    ref_sel  = (mode_r == MODE_TEST) ? EW'(test_ref) : EW'(tgt_r);

    // integrator saturates when its sign bit and the bits above it disagree
    isum    = SUMW'(integ_r) + SUMW'(err_r);
    isum_hi = isum[SUMW-1:IW-1];
    if ((&isum_hi) || !(|isum_hi)) begin
      isat = isum[IW-1:0];
    end else if (isum[SUMW-1]) begin
      isat = {1'b1, {(IW-1){1'b0}}};
    end else begin
      isat = {1'b0, {(IW-1){1'b1}}};
    end

    s_abs    = mul_acc[PW-1] ? -mul_acc : mul_acc;

    // tick below the point limit, which is capped at the counter's top value
    smp_ok   = (CNT_EXT'(tick_r) < CNT_EXT'(test_points_r)) && (tick_r != '1);
    test_end = (mode_r == MODE_TEST) && !smp_ok;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_upd)
            MODE_OPEN:              state_nxt = ST_OPEN;
            MODE_TEST:              state_nxt = ST_TDIV;
            MODE_HOLD, MODE_TRACK:  state_nxt = ST_ERR;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end
      ST_OPEN:      state_nxt = ST_MULD_WAIT;
      ST_TDIV:      state_nxt = ST_TDIV_WAIT;
      ST_TDIV_WAIT: if (div_done) state_nxt = ST_ERR;
      ST_ERR:       state_nxt = ST_INTEG;
      ST_INTEG:     state_nxt = ST_MULP;
      ST_MULP:      state_nxt = ST_MULP_WAIT;
      ST_MULP_WAIT: if (mul_done) state_nxt = ST_MULI;
      ST_MULI:      state_nxt = ST_MULI_WAIT;
      ST_MULI_WAIT: if (mul_done) state_nxt = ST_CLAMP;
      ST_CLAMP:     state_nxt = ST_MULD;
      ST_MULD:      state_nxt = ST_MULD_WAIT;
      ST_MULD_WAIT: if (mul_done) state_nxt = ST_DDIV;
      ST_DDIV:      state_nxt = ST_DDIV_WAIT;
      ST_DDIV_WAIT: if (div_done) state_nxt = ST_DONE;
      ST_DONE:      if (ld_out) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_cmd      = '0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      ST_OPEN: begin
        mul_cmd.start = 1'b1;
        mul_a         = $signed(AW'(open_mag));
        mul_b         = GAIN_W'(pwm_period_r);
      end
      ST_TDIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(tick_r);
        div_divisor  = DVS_W'(hp_eff);
      end
      ST_MULP: begin
        mul_cmd.start = 1'b1;
        mul_a         = AW'(err_r);
        mul_b         = prop_gain_r;
      end
      ST_MULI: begin
        mul_cmd.start = 1'b1;
        mul_cmd.accum = 1'b1;
        mul_a         = AW'(integ_r);
        mul_b         = integ_gain_r;
      end
      ST_MULD: begin
        mul_cmd.start = 1'b1;
        mul_a         = $signed(AW'(mag_r));
        mul_b         = GAIN_W'(pwm_period_r);
      end
      ST_DDIV: begin
        div_start    = 1'b1;
        // closed-loop product is in Q.12 percent: drop the fraction first
        div_dividend = (mode_r == MODE_OPEN) ? mul_acc[DIV_W-1:0] :
                       mul_acc[DIV_W+GAIN_FRAC-1:GAIN_FRAC];
        div_divisor  = DVS_W'(PCT_SCALE);
      end
      default: ;
    endcase
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    ld_out    = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  // datapath and configuration
  always_comb begin
    prop_gain_nxt         = prop_gain_r;
    integ_gain_nxt        = integ_gain_r;
    open_loop_percent_nxt = open_loop_percent_r;
    pwm_period_nxt        = pwm_period_r;
    ref_amplitude_nxt     = ref_amplitude_r;
    ref_half_period_nxt   = ref_half_period_r;
    test_points_nxt       = test_points_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:       prop_gain_nxt         = cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:      integ_gain_nxt        = cfg_data[GAIN_W-1:0];
        CFG_OPEN_LOOP_PCT:   open_loop_percent_nxt = $signed(cfg_data[PCT_W-1:0]);
        CFG_PWM_PERIOD:      pwm_period_nxt        = cfg_data[PERIOD_W-1:0];
        CFG_REF_AMPLITUDE:   ref_amplitude_nxt     = cfg_data[AMP_W-1:0];
        CFG_REF_HALF_PERIOD: ref_half_period_nxt   = cfg_data[HP_W-1:0];
        CFG_TEST_POINTS:     test_points_nxt       = cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end

    mode_nxt      = mode_r;
    integ_nxt     = integ_r;
    tick_nxt      = tick_r;
    meas_nxt      = meas_r;
    tgt_nxt       = tgt_r;
    err_nxt       = err_r;
    mag_nxt       = mag_r;
    res_duty_nxt  = res_duty_r;
    res_rev_nxt   = res_rev_r;

    if (accept) begin
      mode_nxt     = mode_upd;
      meas_nxt     = in_measured_current;
      tgt_nxt      = in_target_current;
      res_duty_nxt = '0;
      res_rev_nxt  = 1'b0;
    end

    case (state_r)
      ST_OPEN:  res_rev_nxt = (open_loop_percent_r <= 0);
      ST_ERR:   err_nxt     = ref_sel - EW'(meas_r);
      ST_INTEG: integ_nxt   = isat;
      ST_CLAMP: begin
        res_rev_nxt = mul_acc[PW-1] || (mul_acc == '0);
        mag_nxt     = (s_abs > FS_P) ? MAG_W'(FULL_SCALE) : s_abs[MAG_W-1:0];
      end
      ST_DDIV_WAIT: if (div_done) res_duty_nxt = div_q[DUTY_W-1:0];
      default: ;
    endcase

    o_duty_nxt    = o_duty_r;
    o_rev_nxt     = o_rev_r;
    o_sval_nxt    = o_sval_r;
    o_sidx_nxt    = o_sidx_r;
    o_scur_nxt    = o_scur_r;
    o_done_nxt    = o_done_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (ld_out) begin
      out_valid_nxt = 1'b1;
      o_duty_nxt    = res_duty_r;
      o_rev_nxt     = res_rev_r;
      o_sval_nxt    = 1'b0;
      o_sidx_nxt    = '0;
      o_scur_nxt    = '0;
      o_done_nxt    = 1'b0;
      if (mode_r == MODE_TEST) begin
        if (smp_ok) begin
          o_sval_nxt = 1'b1;
          o_sidx_nxt = IDX_W'(tick_r);
          o_scur_nxt = meas_r;
          tick_nxt   = tick_r + COUNT_WIDTH'(1);
        end else begin
          // test over: back to idle with a clean integrator
          o_done_nxt = 1'b1;
          tick_nxt   = '0;
          integ_nxt  = '0;
          mode_nxt   = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      mode_r              <= MODE_IDLE;
      integ_r             <= '0;
      tick_r              <= '0;
      out_valid_r         <= 1'b0;
      prop_gain_r         <= RST_PROP_GAIN;
      integ_gain_r        <= RST_INTEG_GAIN;
      open_loop_percent_r <= $signed(RST_OPEN_LOOP_PCT);
      pwm_period_r        <= RST_PWM_PERIOD;
      ref_amplitude_r     <= RST_REF_AMPLITUDE;
      ref_half_period_r   <= RST_REF_HALF_PERIOD;
      test_points_r       <= RST_TEST_POINTS;
    end else begin
      state_r             <= state_nxt;
      mode_r              <= mode_nxt;
      integ_r             <= integ_nxt;
      tick_r              <= tick_nxt;
      out_valid_r         <= out_valid_nxt;
      prop_gain_r         <= prop_gain_nxt;
      integ_gain_r        <= integ_gain_nxt;
      open_loop_percent_r <= open_loop_percent_nxt;
      pwm_period_r        <= pwm_period_nxt;
      ref_amplitude_r     <= ref_amplitude_nxt;
      ref_half_period_r   <= ref_half_period_nxt;
      test_points_r       <= test_points_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    tgt_r      <= tgt_nxt;
    err_r      <= err_nxt;
    mag_r      <= mag_nxt;
    res_duty_r <= res_duty_nxt;
    res_rev_r  <= res_rev_nxt;
    o_duty_r   <= o_duty_nxt;
    o_rev_r    <= o_rev_nxt;
    o_sval_r   <= o_sval_nxt;
    o_sidx_r   <= o_sidx_nxt;
    o_scur_r   <= o_scur_nxt;
    o_done_r   <= o_done_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_duty_count     = o_duty_r;
  assign out_reverse_dir    = o_rev_r;
  assign out_sample_valid   = o_sval_r;
  assign out_sample_index   = o_sidx_r;
  assign out_sample_current = o_scur_r;
  assign out_test_done      = o_done_r;

  // serial units report completion only where the sequencer waits for them
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MULP_WAIT || state_r == ST_MULI_WAIT ||
                  state_r == ST_MULD_WAIT))
    else $error("multiplier finished outside a wait state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_TDIV_WAIT || state_r == ST_DDIV_WAIT))
    else $error("divider finished outside a wait state");

  a_test_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_out && test_end) |=> (mode_r == MODE_IDLE && integ_r == '0 &&
                              tick_r == '0 && out_test_done))
    else $error("test end did not return to idle with cleared state");

endmodule
